@@ rtl/pff_pkg.sv @@
// Shared types and operation and status codes of the channel pool.
package pff_pkg;

  // Operation codes carried in the mode field.
  localparam logic [2:0] MODE_ALLOC        = 3'd0;
  localparam logic [2:0] MODE_WRITE        = 3'd1;
  localparam logic [2:0] MODE_READ         = 3'd2;
  localparam logic [2:0] MODE_CLOSE_READER = 3'd3;
  localparam logic [2:0] MODE_CLOSE_WRITER = 3'd4;

  // Status codes returned with every result.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BLOCK    = 3'd1;
  localparam logic [2:0] ST_EOF      = 3'd2;
  localparam logic [2:0] ST_BROKEN   = 3'd3;
  localparam logic [2:0] ST_NOFREE   = 3'd4;
  localparam logic [2:0] ST_INACTIVE = 3'd5;

  // Widths of the fixed item fields.
  localparam int CHAN_FIELD_W = 3;
  localparam int BYTE_W       = 8;
  localparam int FILL_W       = 9;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CTRL,
    S_DATA
  } state_t;

endpackage

@@ rtl/pff_ram.sv @@
// Single-port-write, single-port-read synchronous memory with registered read data.
module pff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the read data is registered.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/pipe_fifo_pool.sv @@
// Top level of the channel pool: sequencer, channel flags and the two memories.
//
// A pool of CHANNELS byte FIFO channels, each a ring of BUFFER_BYTES bytes. An item
// is taken when start is high and busy is low, and its single result appears on
// status, data_out, channel_out and fill_level for exactly one cycle with done high;
// the receiver cannot hold results off, so it must take them as they come. Every
// item first waits on the channel-state memory (pointers and count), and a read
// that returns a byte then waits on the byte memory as well. A new item may be
// started in the cycle in which the previous result is shown. The byte memory is
// never cleared, since the pointers only reach bytes that were written, so the
// block is ready straight after reset.
module pipe_fifo_pool
  import pff_pkg::*;
#(
  parameter int CHANNELS     = 8,
  parameter int BUFFER_BYTES = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              mode,
  input  logic [CHAN_FIELD_W-1:0] channel,
  input  logic [BYTE_W-1:0]       data_in,
  output logic                    done,
  output logic [2:0]              status,
  output logic [BYTE_W-1:0]       data_out,
  output logic [CHAN_FIELD_W-1:0] channel_out,
  output logic [FILL_W-1:0]       fill_level
);

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W   = $clog2(BUFFER_BYTES);
  localparam int CNT_W   = $clog2(BUFFER_BYTES + 1);
  localparam int DEPTH   = CHANNELS * BUFFER_BYTES;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CTRL_W  = 2 * PTR_W + CNT_W;

  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(BUFFER_BYTES - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(BUFFER_BYTES);
  localparam logic [ADDR_W-1:0] RING_SIZE = ADDR_W'(BUFFER_BYTES);
  localparam logic [31:0]       CHAN_LIM  = 32'(CHANNELS);

  // Per-channel ring state kept in the control memory.
  typedef struct packed {
    logic [PTR_W-1:0] rp;
    logic [PTR_W-1:0] wp;
    logic [CNT_W-1:0] count;
  } ctrl_t;

  state_t state, state_next;

  // Latched item.
  logic [2:0]              op_mode;
  logic [CHAN_FIELD_W-1:0] op_ch;
  logic [BYTE_W-1:0]       op_din;
  logic [CH_W-1:0]         op_idx;
  logic                    op_in_range;
  logic                    chan_ok;
  logic                    accept;

  // Channel flags.
  logic [CHANNELS-1:0] channel_active, reader_open, writer_open;
  logic [CHANNELS-1:0] channel_active_next, reader_open_next, writer_open_next;

  // Lowest free channel.
  logic            free_found;
  logic [CH_W-1:0] free_idx;

  // Memory ports.
  logic              ctrl_we, ctrl_re;
  logic [CH_W-1:0]   ctrl_waddr, ctrl_raddr;
  logic [CTRL_W-1:0] ctrl_wdata, ctrl_rdata;
  ctrl_t             cur, upd;
  logic              byte_we, byte_re;
  logic [ADDR_W-1:0] byte_waddr, byte_raddr;
  logic [BYTE_W-1:0] byte_rdata;

  // Result staging.
  logic                    load_res;
  logic [2:0]              res_status;
  logic [CHAN_FIELD_W-1:0] res_chan;
  logic [FILL_W-1:0]       res_fill;
  logic                    res_last;

  assign busy        = (state != S_IDLE);
  assign accept      = start && !busy;
  assign op_idx      = CH_W'(op_ch);
  assign op_in_range = ({29'd0, op_ch} < CHAN_LIM);
  assign chan_ok     = op_in_range && channel_active[op_idx];
  assign cur         = ctrl_t'(ctrl_rdata);
  assign ctrl_wdata  = CTRL_W'(upd);
  assign ctrl_re     = accept;
  assign ctrl_raddr  = CH_W'(channel);

  // Priority encoder for the lowest channel not in use.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (!channel_active[i]) begin
        free_found = 1'b1;
        free_idx   = CH_W'(i);
      end
    end
  end

  // Channel state memory: read when the item is taken, written back when decided.
  pff_ram #(
    .WIDTH(CTRL_W),
    .DEPTH(CHANNELS)
  ) u_ctrl_ram (
    .clk  (clk),
    .we   (ctrl_we),
    .waddr(ctrl_waddr),
    .wdata(ctrl_wdata),
    .re   (ctrl_re),
    .raddr(ctrl_raddr),
    .rdata(ctrl_rdata)
  );

  // Byte store shared by all rings, each ring occupying BUFFER_BYTES entries.
  pff_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_byte_ram (
    .clk  (clk),
    .we   (byte_we),
    .waddr(byte_waddr),
    .wdata(op_din),
    .re   (byte_re),
    .raddr(byte_raddr),
    .rdata(byte_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_CTRL;
        end
      end
      S_CTRL: begin
        state_next = res_last ? S_IDLE : S_DATA;
      end
      S_DATA: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Decision for the latched item once its channel state has been read.
  always_comb begin
    channel_active_next = channel_active;
    reader_open_next    = reader_open;
    writer_open_next    = writer_open;
    ctrl_we    = 1'b0;
    ctrl_waddr = op_idx;
    upd        = cur;
    byte_we    = 1'b0;
    byte_waddr = ADDR_W'(op_idx) * RING_SIZE + ADDR_W'(cur.wp);
    byte_re    = 1'b0;
    byte_raddr = ADDR_W'(op_idx) * RING_SIZE + ADDR_W'(cur.rp);
    load_res   = 1'b0;
    res_last   = 1'b1;
    res_status = ST_INACTIVE;
    res_chan   = op_ch;
    res_fill   = '0;
    if (state == S_CTRL) begin
      load_res = 1'b1;
      if (op_mode == MODE_ALLOC) begin
        if (free_found) begin
          channel_active_next[free_idx] = 1'b1;
          reader_open_next[free_idx]    = 1'b1;
          writer_open_next[free_idx]    = 1'b1;
          ctrl_we    = 1'b1;
          ctrl_waddr = free_idx;
          upd        = '0;
          res_status = ST_OK;
          res_chan   = CHAN_FIELD_W'(free_idx);
        end else begin
          res_status = ST_NOFREE;
          res_chan   = '0;
        end
      end else if (chan_ok) begin
        case (op_mode)
          MODE_WRITE: begin
            res_fill = FILL_W'(cur.count);
            if (!reader_open[op_idx]) begin
              res_status = ST_BROKEN;
            end else if (cur.count == CNT_FULL) begin
              res_status = ST_BLOCK;
            end else begin
              byte_we    = 1'b1;
              ctrl_we    = 1'b1;
              upd.wp     = (cur.wp == PTR_LAST) ? '0 : cur.wp + 1'b1;
              upd.count  = cur.count + 1'b1;
              res_status = ST_OK;
              res_fill   = FILL_W'(upd.count);
            end
          end
          MODE_READ: begin
            if (cur.count != '0) begin
              byte_re    = 1'b1;
              ctrl_we    = 1'b1;
              upd.rp     = (cur.rp == PTR_LAST) ? '0 : cur.rp + 1'b1;
              upd.count  = cur.count - 1'b1;
              res_status = ST_OK;
              res_fill   = FILL_W'(upd.count);
              res_last   = 1'b0;
            end else begin
              res_status = writer_open[op_idx] ? ST_BLOCK : ST_EOF;
            end
          end
          MODE_CLOSE_READER, MODE_CLOSE_WRITER: begin
            res_status = ST_OK;
            if (op_mode == MODE_CLOSE_READER) begin
              reader_open_next[op_idx] = 1'b0;
            end else begin
              writer_open_next[op_idx] = 1'b0;
            end
            if (!reader_open_next[op_idx] && !writer_open_next[op_idx]) begin
              channel_active_next[op_idx] = 1'b0;
            end else begin
              res_fill = FILL_W'(cur.count);
            end
          end
          default: begin
            res_status = ST_INACTIVE;
          end
        endcase
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      channel_active <= '0;
      reader_open    <= '0;
      writer_open    <= '0;
    end else begin
      state          <= state_next;
      done           <= (load_res && res_last) || (state == S_DATA);
      channel_active <= channel_active_next;
      reader_open    <= reader_open_next;
      writer_open    <= writer_open_next;
    end
  end

  // Item and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode <= mode;
      op_ch   <= channel;
      op_din  <= data_in;
    end
    if (load_res) begin
      status      <= res_status;
      channel_out <= res_chan;
      fill_level  <= res_fill;
      data_out    <= '0;
    end else if (state == S_DATA) begin
      data_out <= byte_rdata;
    end
  end

  // A result only follows the decision or the byte fetch.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_CTRL || $past(state) == S_DATA))
    else $error("result strobe without a preceding decision");

  // A byte fetch always ends in a successful result.
  a_fetch_ok: assert property (@(posedge clk) disable iff (rst)
    (state == S_DATA) |=> (done && status == ST_OK))
    else $error("byte fetch did not deliver a successful read");

  // Open ends exist exactly on channels in use.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    (((reader_open | writer_open) ^ channel_active) == '0))
    else $error("channel flags inconsistent");

  // An accepted item moves straight to the decision step.
  a_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_CTRL && !done))
    else $error("accepted item not sequenced");

  // A refused allocation reports no channel and no fill.
  a_nofree: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_NOFREE) |-> (channel_out == '0 && fill_level == '0))
    else $error("refused allocation carries data");

endmodule

@@ bench/pipe_fifo_pool_test.sv @@
// Self-checking testbench for the channel pool, checked against a channel model.
module pipe_fifo_pool_test
  import pff_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CH        = 8;
  localparam int RING_BYTES    = 256;
  localparam int PTR_W         = $clog2(RING_BYTES);
  localparam int TOTAL_ITEMS   = 1150;
  localparam int CLOSING_ITEMS = 100;
  localparam int FILL_AFTER    = 300;
  localparam int STALL_LIMIT   = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT  = 10;

  // Highest mode value, beyond the defined operations, which the block must reject.
  localparam logic [2:0] MODE_SPARE_LAST  = '1;

  typedef struct packed {
    logic [2:0]              mode;
    logic [CHAN_FIELD_W-1:0] channel;
    logic [BYTE_W-1:0]       data;
  } pool_item_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [BYTE_W-1:0]       data_out;
    logic [CHAN_FIELD_W-1:0] channel_out;
    logic [FILL_W-1:0]       fill_level;
  } pool_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [2:0]              mode = '0;
  logic [CHAN_FIELD_W-1:0] channel = '0;
  logic [BYTE_W-1:0]       data_in = '0;
  logic                    done;
  logic [2:0]              status;
  logic [BYTE_W-1:0]       data_out;
  logic [CHAN_FIELD_W-1:0] channel_out;
  logic [FILL_W-1:0]       fill_level;

  // Model of every channel: ring contents, pointers, fill and end flags.
  logic [BYTE_W-1:0] ring_mem [NUM_CH][RING_BYTES];
  logic [PTR_W-1:0]  rd_ptr [NUM_CH] = '{default: '0};
  logic [PTR_W-1:0]  wr_ptr [NUM_CH] = '{default: '0};
  logic [FILL_W-1:0] held [NUM_CH] = '{default: '0};
  logic              ch_active [NUM_CH] = '{default: 1'b0};
  logic              rd_open [NUM_CH] = '{default: 1'b0};
  logic              wr_open [NUM_CH] = '{default: 1'b0};

  pool_item_t   pending_items [$];
  pool_result_t expected_results [$];
  pool_item_t   on_ports;
  int           gap_left = 0;
  bit           gaps_on = 1'b1;
  int           planned_items = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;

  pipe_fifo_pool #(
    .CHANNELS    (NUM_CH),
    .BUFFER_BYTES(RING_BYTES)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .channel    (channel),
    .data_in    (data_in),
    .done       (done),
    .status     (status),
    .data_out   (data_out),
    .channel_out(channel_out),
    .fill_level (fill_level)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Lowest channel that is free, or -1 when the pool is exhausted.
  function automatic int lowest_free();
    int grant;
    grant = -1;
    for (int i = NUM_CH - 1; i >= 0; i--) begin
      if (!ch_active[i]) grant = i;
    end
    return grant;
  endfunction

  // Apply one item to the channel model and return the result it must produce.
  function automatic pool_result_t predict_pool(pool_item_t it);
    pool_result_t r;
    int c;
    int grant;
    c = int'(it.channel);
    r = '{ST_OK, '0, it.channel, '0};
    if (it.mode == MODE_ALLOC) begin
      grant = lowest_free();
      if (grant < 0) begin
        r.status = ST_NOFREE;
        r.channel_out = '0;
      end else begin
        ch_active[grant] = 1'b1;
        rd_open[grant] = 1'b1;
        wr_open[grant] = 1'b1;
        rd_ptr[grant] = '0;
        wr_ptr[grant] = '0;
        held[grant] = '0;
        r.channel_out = grant[CHAN_FIELD_W-1:0];
      end
    end else if (it.mode > MODE_CLOSE_WRITER || !ch_active[c]) begin
      r.status = ST_INACTIVE;
    end else if (it.mode == MODE_WRITE) begin
      if (!rd_open[c]) begin
        r.status = ST_BROKEN;
      end else if (held[c] >= FILL_W'(RING_BYTES)) begin
        r.status = ST_BLOCK;
      end else begin
        ring_mem[c][wr_ptr[c]] = it.data;
        wr_ptr[c] = wr_ptr[c] + 1'b1;
        held[c] = held[c] + 1'b1;
      end
      r.fill_level = held[c];
    end else if (it.mode == MODE_READ) begin
      if (held[c] != '0) begin
        r.data_out = ring_mem[c][rd_ptr[c]];
        rd_ptr[c] = rd_ptr[c] + 1'b1;
        held[c] = held[c] - 1'b1;
        r.fill_level = held[c];
      end else if (wr_open[c]) begin
        r.status = ST_BLOCK;
      end else begin
        r.status = ST_EOF;
      end
    end else begin
      if (it.mode == MODE_CLOSE_READER) rd_open[c] = 1'b0;
      else wr_open[c] = 1'b0;
      if (!rd_open[c] && !wr_open[c]) ch_active[c] = 1'b0;
      else r.fill_level = held[c];
    end
    return r;
  endfunction

  function automatic void push_item(logic [2:0] m, int ch, int d);
    pool_item_t it;
    it.mode = m;
    it.channel = ch[CHAN_FIELD_W-1:0];
    it.data = d[BYTE_W-1:0];
    pending_items.push_back(it);
    planned_items++;
  endfunction

  function automatic logic [2:0] rw_mode(int write_pct);
    return ($urandom_range(0, 99) < write_pct) ? MODE_WRITE : MODE_READ;
  endfunction

  // Pick an allocated channel, optionally one whose reader is still open. When
  // none fits, items that open a channel are queued and the granted index is
  // returned. Only valid while no item is pending, so the model is current.
  function automatic int claim_channel(bit need_reader);
    int fits [$];
    int grant;
    for (int i = 0; i < NUM_CH; i++) begin
      if (ch_active[i] && (rd_open[i] || !need_reader)) fits.push_back(i);
    end
    if (fits.size() != 0) return fits[$urandom_range(0, fits.size() - 1)];
    grant = lowest_free();
    if (grant < 0) begin
      // Every channel has its reader closed: closing the writer frees channel 0.
      push_item(MODE_CLOSE_WRITER, 0, $urandom_range(0, 255));
      grant = 0;
    end
    push_item(MODE_ALLOC, $urandom_range(0, NUM_CH - 1), $urandom_range(0, 255));
    return grant;
  endfunction

  // A byte stream on one channel, with a few stray accesses to random channels.
  function automatic void gen_stream(int len);
    int ch;
    int write_pct;
    ch = claim_channel(1'b1);
    write_pct = $urandom_range(30, 70);
    repeat (len) begin
      if ($urandom_range(0, 99) < 85) begin
        push_item(rw_mode(write_pct), ch, $urandom_range(0, 255));
      end else begin
        push_item(rw_mode(50), $urandom_range(0, NUM_CH - 1), $urandom_range(0, 255));
      end
    end
  endfunction

  // Close one end of a channel, and usually the other, in random order with traffic in between.
  function automatic void gen_shutdown();
    int ch;
    logic [2:0] first_end;
    logic [2:0] second_end;
    ch = claim_channel(1'b0);
    first_end = $urandom_range(0, 1) ? MODE_CLOSE_READER : MODE_CLOSE_WRITER;
    second_end = (first_end == MODE_CLOSE_READER) ? MODE_CLOSE_WRITER : MODE_CLOSE_READER;
    push_item(first_end, ch, $urandom_range(0, 255));
    repeat ($urandom_range(1, 5)) push_item(rw_mode(50), ch, $urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) push_item(first_end, ch, $urandom_range(0, 255));
    if ($urandom_range(0, 9) < 7) begin
      push_item(second_end, ch, $urandom_range(0, 255));
      repeat ($urandom_range(0, 2)) push_item(rw_mode(50), ch, $urandom_range(0, 255));
      if ($urandom_range(0, 1) == 1) begin
        push_item(MODE_ALLOC, $urandom_range(0, NUM_CH - 1), $urandom_range(0, 255));
      end
    end
  endfunction

  // Write one channel past full, then read it past empty.
  function automatic void gen_fill_drain();
    int ch;
    int room;
    ch = claim_channel(1'b1);
    room = ch_active[ch] ? RING_BYTES - int'(held[ch]) : RING_BYTES;
    repeat (room + 2) push_item(MODE_WRITE, ch, $urandom_range(0, 255));
    repeat (RING_BYTES + 2) push_item(MODE_READ, ch, $urandom_range(0, 255));
  endfunction

  function automatic void log_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
  endfunction

  // Present pending items on the ports; update the model on each accepted item.
  always @(posedge clk) begin
    bit taken;
    taken = start && !busy;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (taken) expected_results.push_back(predict_pool(on_ports));
      if (!start || taken) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_items.size() == 0) begin
          start <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 7);
          start <= 1'b0;
        end else begin
          on_ports = pending_items.pop_front();
          start <= 1'b1;
          mode <= on_ports.mode;
          channel <= on_ports.channel;
          data_in <= on_ports.data;
        end
      end
    end
  end

  // Compare each result with the oldest outstanding prediction.
  always @(posedge clk) begin
    pool_result_t want;
    pool_result_t got;
    string diffs;
    if (!rst && done) begin
      got = '{status, data_out, channel_out, fill_level};
      if (expected_results.size() == 0) begin
        log_mismatch($sformatf(
          "result with none expected: status %0d data %0h chan %0d fill %0d",
          got.status, got.data_out, got.channel_out, got.fill_level));
      end else begin
        want = expected_results.pop_front();
        diffs = "";
        if (got.status !== want.status) diffs = {diffs, " status"};
        if (got.data_out !== want.data_out) diffs = {diffs, " data_out"};
        if (got.channel_out !== want.channel_out) diffs = {diffs, " channel_out"};
        if (got.fill_level !== want.fill_level) diffs = {diffs, " fill_level"};
        if (diffs != "") begin
          log_mismatch($sformatf(
            "mismatch in%s: expected %0d/%0h/%0d/%0d, got %0d/%0h/%0d/%0d", diffs,
            want.status, want.data_out, want.channel_out, want.fill_level,
            got.status, got.data_out, got.channel_out, got.fill_level));
        end
      end
    end
  end

  // Count cycles in which neither an item nor a result is taken.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    bit fill_done;
    int pick;
    fill_done = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: unopened channel, unknown mode, pool exhaustion.
    push_item(MODE_READ, 0, 0);
    push_item(MODE_SPARE_LAST, NUM_CH - 1, 'hFF);
    repeat (NUM_CH) push_item(MODE_ALLOC, 0, 0);
    push_item(MODE_ALLOC, NUM_CH - 1, 'hFF);
    // Data extremes through channel 0, then empty with writer open.
    push_item(MODE_WRITE, 0, 'hFF);
    push_item(MODE_WRITE, 0, 'h00);
    repeat (3) push_item(MODE_READ, 0, 0);
    // Writer closed twice, end of file, then a write after the writer closed.
    repeat (2) push_item(MODE_CLOSE_WRITER, 0, 0);
    push_item(MODE_READ, 0, 0);
    push_item(MODE_WRITE, 0, 'h5A);
    // Read of held data after the reader closed, then a broken pipe.
    push_item(MODE_WRITE, 1, 'hA5);
    push_item(MODE_CLOSE_READER, 1, 0);
    push_item(MODE_READ, 1, 0);
    push_item(MODE_WRITE, 1, 'h3C);
    // Channel freed while holding a byte, then reopened empty.
    push_item(MODE_CLOSE_READER, 0, 0);
    push_item(MODE_ALLOC, 0, 0);
    push_item(MODE_READ, 0, 0);

    // Random sequences, each built once the model has caught up.
    while (planned_items < TOTAL_ITEMS - CLOSING_ITEMS) begin
      wait (pending_items.size() == 0 && !start);
      gaps_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (!fill_done && planned_items >= FILL_AFTER) begin
        gen_fill_drain();
        fill_done = 1'b1;
      end else if (pick < 45) begin
        gen_stream($urandom_range(4, 24));
      end else if (pick < 65) begin
        gen_shutdown();
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 3)) push_item(MODE_ALLOC, $urandom_range(0, NUM_CH - 1),
                                               $urandom_range(0, 255));
      end else begin
        repeat ($urandom_range(1, 6)) push_item(3'($urandom_range(0, MODE_SPARE_LAST)),
                                               $urandom_range(0, NUM_CH - 1),
                                               $urandom_range(0, 255));
      end
    end

    // Closing stretch at full rate.
    wait (pending_items.size() == 0 && !start);
    gaps_on = 1'b0;
    gen_stream(CLOSING_ITEMS);

    wait (pending_items.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
